FILE: sv/uet_pkg.sv
// ----------------------------------------------------------------------------
// uet_pkg: shared types and constants for the undirected edge table
// Request codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package uet_pkg;
  localparam int MAX_EDGES_DEF = 20;
  localparam int ADDR_BITS_DEF = 16;
  localparam int SLOT_W = 5;
  localparam int CNT_W = 5;
  localparam int OUT_ADDR_W = 16;

  localparam logic [2:0] REQ_LOOKUP = 3'd0;
  localparam logic [2:0] REQ_ADD    = 3'd1;
  localparam logic [2:0] REQ_PURGE  = 3'd2;
  localparam logic [2:0] REQ_RMSLOT = 3'd3;
  localparam logic [2:0] REQ_FLUSH  = 3'd4;
  localparam logic [2:0] REQ_RANK   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic scan;     // examine entry at scan position
    logic commit;   // apply the decided update
    logic finish;   // build result word
  } uet_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } uet_sts_t;
endpackage

FILE: sv/uet_if.sv
// ----------------------------------------------------------------------------
// uet_req_if / uet_rsp_if: valid/ready channels
// Request and result channels of the edge table.
// ----------------------------------------------------------------------------
interface uet_req_if #(parameter int ADDR_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [2:0]           req_type;
  logic [ADDR_BITS-1:0] first_addr;
  logic [ADDR_BITS-1:0] second_addr;
  logic [4:0]           slot_or_rank;
  modport source (output valid, req_type, first_addr, second_addr, slot_or_rank,
                  input ready);
  modport sink (input valid, req_type, first_addr, second_addr, slot_or_rank,
                output ready);
endinterface

interface uet_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [4:0]  entry_slot;
  logic [15:0] entry_src;
  logic [15:0] entry_dst;
  logic [4:0]  removed_count;
  logic [4:0]  edge_count;
  logic [1:0]  status;
  modport source (output valid, hit, entry_slot, entry_src, entry_dst,
                  removed_count, edge_count, status, input ready);
  modport sink (input valid, hit, entry_slot, entry_src, entry_dst,
                removed_count, edge_count, status, output ready);
endinterface

FILE: sv/uet_ctrl.sv
// ----------------------------------------------------------------------------
// uet_ctrl: request sequencer
// Load, scan the recency order one entry a cycle, commit, present result.
// ----------------------------------------------------------------------------
module uet_ctrl
  import uet_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  uet_sts_t sts,
  output uet_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMMIT, S_FINISH, S_HOLD} state_t;
  state_t state_r;
  logic   out_valid_r;

  // accept the next word once the result slot is free
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.load   = in_valid && in_ready;
    cmd.scan   = (state_r == S_SCAN) && !sts.scan_done;
    cmd.commit = (state_r == S_COMMIT);
    cmd.finish = (state_r == S_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE:   if (in_valid && in_ready) state_r <= S_SCAN;
        S_SCAN:   if (sts.scan_done) state_r <= S_COMMIT;
        S_COMMIT: state_r <= S_FINISH;
        S_FINISH: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/uet_dp.sv
// ----------------------------------------------------------------------------
// uet_dp: edge table datapath
// Slot store, recency list and the per-entry match logic used by the scan.
// ----------------------------------------------------------------------------
module uet_dp
  import uet_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  uet_cmd_t             cmd,
  output uet_sts_t             sts,
  input  logic [2:0]           in_req,
  input  logic [ADDR_BITS-1:0] in_a,
  input  logic [ADDR_BITS-1:0] in_b,
  input  logic [4:0]           in_idx,
  output logic                 o_hit,
  output logic [4:0]           o_slot,
  output logic [15:0]          o_src,
  output logic [15:0]          o_dst,
  output logic [4:0]           o_removed,
  output logic [4:0]           o_count,
  output logic [1:0]           o_status
);
  localparam int SW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int PW = $clog2(MAX_EDGES + 1);

  logic [MAX_EDGES-1:0] valid_r;
  logic [ADDR_BITS-1:0] src_r [MAX_EDGES];
  logic [ADDR_BITS-1:0] dst_r [MAX_EDGES];
  logic [SW-1:0]        ord_r [MAX_EDGES];
  logic [PW-1:0]        total_r;

  logic [2:0]           req_r;
  logic [ADDR_BITS-1:0] a_r, b_r;
  logic [4:0]           idx_r;
  logic [PW-1:0]        pos_r;     // scan read position
  logic [PW-1:0]        wpos_r;    // compaction write position (purge)
  logic                 found_r;
  logic [PW-1:0]        fpos_r;
  logic [PW-1:0]        removed_r;

  logic [SW-1:0]        cur_slot;
  logic                 pair_m, addr_m, slot_m, done;
  logic [SW-1:0]        free_slot;
  logic                 free_ok;

  assign cur_slot = ord_r[pos_r[SW-1:0]];
  assign pair_m = (src_r[cur_slot] == a_r && dst_r[cur_slot] == b_r) ||
                  (src_r[cur_slot] == b_r && dst_r[cur_slot] == a_r);
  assign addr_m = (src_r[cur_slot] == a_r) || (dst_r[cur_slot] == a_r);
  assign slot_m = ({{(32-SW){1'b0}}, cur_slot} == {27'd0, idx_r});
  assign done   = (pos_r >= total_r) ||
                  (req_r != REQ_LOOKUP && req_r != REQ_ADD &&
                   req_r != REQ_PURGE && req_r != REQ_RMSLOT);
  assign sts.scan_done = done;

  // lowest free slot (priority encoder)
  always_comb begin
    free_slot = '0;
    free_ok   = 1'b0;
    for (int i = MAX_EDGES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot = SW'(i);
        free_ok   = 1'b1;
      end
    end
  end

  logic [SW-1:0] fslot;
  assign fslot = ord_r[fpos_r[SW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
    end else begin
      if (cmd.load) begin
        req_r <= in_req; a_r <= in_a; b_r <= in_b; idx_r <= in_idx;
        pos_r <= '0; wpos_r <= '0; found_r <= 1'b0; fpos_r <= '0;
        removed_r <= '0;
      end
      if (cmd.scan) begin
        pos_r <= pos_r + 1'b1;
        case (req_r)
          REQ_LOOKUP, REQ_ADD: if (pair_m) begin found_r <= 1'b1; fpos_r <= pos_r; end
          REQ_RMSLOT: if (slot_m) begin found_r <= 1'b1; fpos_r <= pos_r; end
          REQ_PURGE: begin
            if (addr_m) begin
              valid_r[cur_slot] <= 1'b0;
              removed_r <= removed_r + 1'b1;
            end else begin
              // keep survivors in order, compact toward the front
              ord_r[wpos_r[SW-1:0]] <= cur_slot;
              wpos_r <= wpos_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.commit) begin
        o_hit <= 1'b0; o_slot <= '0; o_src <= '0; o_dst <= '0;
        o_removed <= '0; o_status <= ST_MISS;
        case (req_r)
          REQ_LOOKUP, REQ_ADD: begin
            if (found_r) begin
              for (int i = 1; i < MAX_EDGES; i++)
                if (PW'(i) <= fpos_r) ord_r[i] <= ord_r[i-1];
              ord_r[0] <= fslot;
              o_hit <= 1'b1; o_status <= ST_OK;
              o_slot <= 5'(fslot);
              o_src <= 16'(src_r[fslot]); o_dst <= 16'(dst_r[fslot]);
            end else if (req_r == REQ_ADD) begin
              if (!free_ok || total_r >= PW'(MAX_EDGES)) begin
                o_status <= ST_FULL;
              end else begin
                valid_r[free_slot] <= 1'b1;
                src_r[free_slot] <= a_r; dst_r[free_slot] <= b_r;
                for (int i = 1; i < MAX_EDGES; i++) ord_r[i] <= ord_r[i-1];
                ord_r[0] <= free_slot;
                total_r <= total_r + 1'b1;
                o_hit <= 1'b1; o_status <= ST_OK;
                o_slot <= 5'(free_slot);
                o_src <= 16'(a_r); o_dst <= 16'(b_r);
              end
            end
          end
          REQ_PURGE: begin
            total_r <= wpos_r;
            o_removed <= 5'(removed_r);
            o_hit <= (removed_r != '0);
            o_status <= (removed_r != '0) ? ST_OK : ST_MISS;
          end
          REQ_RMSLOT: begin
            if (found_r) begin
              for (int i = 0; i < MAX_EDGES - 1; i++)
                if (PW'(i) >= fpos_r) ord_r[i] <= ord_r[i+1];
              valid_r[fslot] <= 1'b0;
              total_r <= total_r - 1'b1;
              o_hit <= 1'b1; o_status <= ST_OK; o_removed <= 5'd1;
              o_slot <= 5'(fslot);
              o_src <= 16'(src_r[fslot]); o_dst <= 16'(dst_r[fslot]);
            end
          end
          REQ_FLUSH: begin
            valid_r <= '0; total_r <= '0;
            o_removed <= 5'(total_r);
            o_hit <= (total_r != '0); o_status <= ST_OK;
          end
          REQ_RANK: begin
            if ({27'd0, idx_r} < {{(32-PW){1'b0}}, total_r}) begin
              o_hit <= 1'b1; o_status <= ST_OK;
              o_slot <= 5'(ord_r[idx_r[SW-1:0]]);
              o_src <= 16'(src_r[ord_r[idx_r[SW-1:0]]]);
              o_dst <= 16'(dst_r[ord_r[idx_r[SW-1:0]]]);
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish) o_count <= 5'(total_r);
    end
  end
endmodule

FILE: sv/undirected_edge_table_mru.sv
// ----------------------------------------------------------------------------
// undirected_edge_table_mru: undirected edge table with recency order
// Top level: sequencer plus datapath behind valid/ready channels.
// ----------------------------------------------------------------------------
// Each request word on the in_ channel (lookup, add, purge by address, remove
// slot, flush, read rank) gives exactly one result word on the out_ channel.
// A request walks the recency list one entry a cycle, then the commit state
// applies the update and the finish state completes the result; one request is
// handled at a time. Flush, read rank and unused codes skip the scan.
// A new request is taken only once the previous result has been taken, so
// a stalled receiver holds the result word and blocks further requests.
// After reset the table is empty; the slot addresses are not cleared.
// ----------------------------------------------------------------------------
module undirected_edge_table_mru
  import uet_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  uet_req_if.sink   in_ch,
  uet_rsp_if.source out_ch
);
  uet_cmd_t cmd;
  uet_sts_t sts;

  uet_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  uet_dp #(.MAX_EDGES(MAX_EDGES), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_req(in_ch.req_type), .in_a(in_ch.first_addr), .in_b(in_ch.second_addr),
    .in_idx(in_ch.slot_or_rank),
    .o_hit(out_ch.hit), .o_slot(out_ch.entry_slot), .o_src(out_ch.entry_src),
    .o_dst(out_ch.entry_dst), .o_removed(out_ch.removed_count),
    .o_count(out_ch.edge_count), .o_status(out_ch.status)
  );

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("request taken with result pending");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !out_ch.valid) else $error("early result");
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.hit) |-> (out_ch.status == ST_OK))
    else $error("hit with error status");
endmodule
